FILE: design/srdc_pkg.sv
// shared constants, types and helper functions of the stepper rate divider calculator
package srdc_pkg;

  // timer and motor constants
  localparam int unsigned TIMER_CLOCK_HZ = 84000000;
  localparam int unsigned RELOAD_LIMIT   = 65535;
  localparam int unsigned STEPS_PER_REV  = 200;
  localparam int unsigned MAX_DIVISOR    = 256;
  localparam int unsigned FIRST_DIVISOR  = 2;
  localparam int unsigned FRAC_BITS      = 8;
  localparam int unsigned MAX_USHIFT     = 8;

  // smallest divisor product for which the reload fits below the limit is above this
  localparam int unsigned RELOAD_THRESH = TIMER_CLOCK_HZ / (RELOAD_LIMIT + 1);
  localparam longint unsigned COUNT_MAX = 64'd2147483647;

  // transaction field widths
  localparam int unsigned SPEED_W  = 8;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned CUR_W    = 8;
  localparam int unsigned RELOAD_W = 16;
  localparam int unsigned PRESC_W  = 8;
  localparam int unsigned COUNT_W  = 31;
  localparam int unsigned USTEP_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // internal datapath widths
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned CLK_W   = 29;
  localparam int unsigned FREQ_W  = 26;
  localparam int unsigned PROD_W  = 34;
  localparam int unsigned DIV_W   = 9;
  localparam int unsigned DCNT_W  = 5;
  localparam int unsigned MAG_W   = 24;
  localparam int unsigned STEPS_W = 34;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_USTEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_USTEP = 2'd1;

  // request types
  localparam logic REQ_SET_SPEED = 1'b0;
  localparam logic REQ_RUN       = 1'b1;

  // microstep factor as a power-of-two shift, indexes past the table give shift MAX_USHIFT
  function automatic logic [SHIFT_W-1:0] ustep_shift(input logic [USTEP_W-1:0] idx);
    logic [SHIFT_W-1:0] sh;
    unique case (idx)
      4'd0, 4'd1: sh = 4'd0;
      4'd2, 4'd3: sh = 4'd1;
      4'd4:       sh = 4'd2;
      4'd5:       sh = 4'd3;
      4'd6:       sh = 4'd4;
      4'd7:       sh = 4'd5;
      4'd8:       sh = 4'd6;
      4'd9:       sh = 4'd7;
      default:    sh = SHIFT_W'(MAX_USHIFT);
    endcase
    return sh;
  endfunction

  // divider command and status
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic             done;
    logic [CLK_W-1:0] quot;
  } div_status_t;

  // one result transaction
  typedef struct packed {
    logic                axis;
    logic [RELOAD_W-1:0] reload_value;
    logic [PRESC_W-1:0]  prescale;
    logic                pwm_off;
    logic                move_start;
    logic                direction;
    logic [COUNT_W-1:0]  step_count;
    logic [CUR_W-1:0]    drv_current;
    logic                rate_error;
  } result_t;

endpackage

FILE: design/srdc_cfg_if.sv
// configuration write channel
interface srdc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [srdc_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [srdc_pkg::USTEP_W-1:0]       wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: design/srdc_in_if.sv
// command input channel
interface srdc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic                                axis;
  logic [srdc_pkg::SPEED_W-1:0]        speed;
  logic signed [srdc_pkg::LEN_W-1:0]   length_q8;
  logic [srdc_pkg::CUR_W-1:0]          drive_current;

  modport source (output valid, output req_type, output axis, output speed,
                  output length_q8, output drive_current, input ready);
  modport sink (input valid, input req_type, input axis, input speed,
                input length_q8, input drive_current, output ready);
endinterface

FILE: design/srdc_out_if.sv
// result output channel
interface srdc_out_if;
  logic                            valid;
  logic                            ready;
  logic                            out_axis;
  logic [srdc_pkg::RELOAD_W-1:0]   reload_value;
  logic [srdc_pkg::PRESC_W-1:0]    prescale;
  logic                            pwm_off;
  logic                            move_start;
  logic                            direction;
  logic [srdc_pkg::COUNT_W-1:0]    step_count;
  logic [srdc_pkg::CUR_W-1:0]      out_current;
  logic                            rate_error;

  modport source (output valid, output out_axis, output reload_value, output prescale,
                  output pwm_off, output move_start, output direction, output step_count,
                  output out_current, output rate_error, input ready);
  modport sink (input valid, input out_axis, input reload_value, input prescale,
                input pwm_off, input move_start, input direction, input step_count,
                input out_current, input rate_error, output ready);
endinterface

FILE: design/srdc_div.sv
// bit-serial restoring divider of the timer clock by a divisor product
module srdc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  srdc_pkg::div_cmd_t    cmd,
  output srdc_pkg::div_status_t status
);

  logic                          busy_r;
  logic                          done_r;
  logic [srdc_pkg::DCNT_W-1:0]   cnt_r;
  logic [srdc_pkg::CLK_W-1:0]    dvd_r;
  logic [srdc_pkg::CLK_W-1:0]    quot_r;
  logic [srdc_pkg::PROD_W-1:0]   rem_r;
  logic [srdc_pkg::PROD_W-1:0]   dsr_r;
  logic [srdc_pkg::PROD_W:0]     trial;
  logic [srdc_pkg::PROD_W:0]     diff;
  logic                          fits;

  // one quotient bit per cycle
  assign trial = {rem_r, dvd_r[srdc_pkg::CLK_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = trial >= {1'b0, dsr_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= srdc_pkg::DCNT_W'(srdc_pkg::CLK_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd_r  <= srdc_pkg::CLK_W'(srdc_pkg::TIMER_CLOCK_HZ);
      rem_r  <= '0;
      dsr_r  <= cmd.divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[srdc_pkg::CLK_W-2:0], 1'b0};
      rem_r  <= fits ? diff[srdc_pkg::PROD_W-1:0] : trial[srdc_pkg::PROD_W-1:0];
      quot_r <= {quot_r[srdc_pkg::CLK_W-2:0], fits};
    end
  end

  assign status.done = done_r;
  assign status.quot = quot_r;

endmodule

FILE: design/stepper_rate_divider_calc_top.sv
// stepper rate divider calculator top level
//
// Takes one stepper command per transaction on in_chan (set speed or run a move
// for axis x or y) and returns one result transaction on out_chan with timer
// reload and prescale values, and for a run the step count, direction and current.
// cfg_chan writes the per-axis microstep table indexes; it is always ready and
// should only be written while no command is in flight.
//
// A command with nonzero speed first searches divisors 2, 3, ... one per cycle by
// accumulating the step frequency, then divides the timer clock by the chosen
// product in a bit-serial divider; a command with speed zero skips both.
// One command is in work at a time; in_chan is ready again once the result has
// moved into the output register.
// The output register holds a result while the receiver stalls, and the next
// command may be accepted and computed meanwhile; it then waits until the
// output register frees up.
// Reset clears the microstep indexes to zero and empties the output register.
module stepper_rate_divider_calc_top (
  input  logic       clk,
  input  logic       rst_n,
  srdc_cfg_if.sink   cfg_chan,
  srdc_in_if.sink    in_chan,
  srdc_out_if.source out_chan
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_DIVIDE = 4'b0100,
    S_HOLD   = 4'b1000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [srdc_pkg::USTEP_W-1:0]   x_ustep_r, y_ustep_r;
  logic [srdc_pkg::FREQ_W-1:0]    freq_r, freq_nxt;
  logic [srdc_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic [srdc_pkg::DIV_W-1:0]     dsel_r, dsel_nxt;
  srdc_pkg::result_t              res_r, res_nxt;
  srdc_pkg::result_t              out_r;
  logic                           out_valid_r, out_valid_nxt;
  logic                           in_acc, out_load;
  srdc_pkg::div_cmd_t             div_cmd;
  srdc_pkg::div_status_t          div_st;

  logic [srdc_pkg::SHIFT_W-1:0]   shift_sel;
  logic [srdc_pkg::FREQ_W-1:0]    base_freq, freq_in;
  logic                           len_neg;
  logic [srdc_pkg::MAG_W-1:0]     mag;
  logic [srdc_pkg::STEPS_W-1:0]   steps_raw;
  logic [srdc_pkg::COUNT_W-1:0]   steps_sat;
  logic                           prod_fits, prod_over;

  // serial divider
  srdc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (div_cmd),
    .status (div_st)
  );

  // configuration registers
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_ustep_r <= '0;
      y_ustep_r <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      if (cfg_chan.reg_index == srdc_pkg::REG_X_USTEP) begin
        x_ustep_r <= cfg_chan.wdata;
      end
      if (cfg_chan.reg_index == srdc_pkg::REG_Y_USTEP) begin
        y_ustep_r <= cfg_chan.wdata;
      end
    end
  end

  // handshakes
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == S_HOLD) && (!out_valid_r || out_chan.ready);
  assign out_valid_nxt = out_load || (out_valid_r && !out_chan.ready);

  // step frequency and step count of the incoming command
  assign shift_sel = srdc_pkg::ustep_shift(in_chan.axis ? y_ustep_r : x_ustep_r);
  assign base_freq = srdc_pkg::FREQ_W'(in_chan.speed)
                   * srdc_pkg::FREQ_W'(srdc_pkg::STEPS_PER_REV);
  assign freq_in   = base_freq << shift_sel;
  assign len_neg   = in_chan.length_q8[srdc_pkg::LEN_W-1];
  assign mag       = len_neg ? srdc_pkg::MAG_W'(-in_chan.length_q8)
                             : srdc_pkg::MAG_W'(in_chan.length_q8);
  assign steps_raw = (srdc_pkg::STEPS_W'(mag) * srdc_pkg::STEPS_W'(srdc_pkg::STEPS_PER_REV))
                   >> (srdc_pkg::SHIFT_W'(srdc_pkg::FRAC_BITS) - shift_sel);
  assign steps_sat = (steps_raw > srdc_pkg::STEPS_W'(srdc_pkg::COUNT_MAX))
                   ? srdc_pkg::COUNT_W'(srdc_pkg::COUNT_MAX)
                   : steps_raw[srdc_pkg::COUNT_W-1:0];

  // divisor search compares
  assign prod_fits = prod_r > srdc_pkg::PROD_W'(srdc_pkg::RELOAD_THRESH);
  assign prod_over = prod_r > srdc_pkg::PROD_W'(srdc_pkg::TIMER_CLOCK_HZ);

  assign div_cmd.start   = (state_r == S_SEARCH) && prod_fits && !prod_over;
  assign div_cmd.divisor = prod_r;

  // command sequencer
  always_comb begin
    state_nxt = state_r;
    freq_nxt  = freq_r;
    prod_nxt  = prod_r;
    dsel_nxt  = dsel_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt      = '0;
          res_nxt.axis = in_chan.axis;
          freq_nxt     = freq_in;
          prod_nxt     = srdc_pkg::PROD_W'(freq_in) << 1;
          dsel_nxt     = srdc_pkg::DIV_W'(srdc_pkg::FIRST_DIVISOR);
          if (in_chan.req_type == srdc_pkg::REQ_RUN) begin
            res_nxt.drv_current = in_chan.drive_current;
            if (in_chan.speed == '0) begin
              res_nxt.rate_error = 1'b1;
              state_nxt          = S_HOLD;
            end else begin
              if (steps_sat != '0) begin
                res_nxt.move_start = 1'b1;
                res_nxt.direction  = len_neg;
                res_nxt.step_count = steps_sat;
              end
              state_nxt = S_SEARCH;
            end
          end else begin
            if (in_chan.speed == '0) begin
              res_nxt.pwm_off = 1'b1;
              state_nxt       = S_HOLD;
            end else begin
              state_nxt = S_SEARCH;
            end
          end
        end
      end
      S_SEARCH: begin
        priority if (prod_fits && prod_over) begin
          // frequency too high for the first divisor, or no divisor fits
          if (dsel_r == srdc_pkg::DIV_W'(srdc_pkg::FIRST_DIVISOR)) begin
            res_nxt.reload_value = '0;
            res_nxt.prescale     = srdc_pkg::PRESC_W'(srdc_pkg::FIRST_DIVISOR - 1);
          end else begin
            res_nxt.reload_value = srdc_pkg::RELOAD_W'(srdc_pkg::RELOAD_LIMIT - 1);
            res_nxt.prescale     = srdc_pkg::PRESC_W'(srdc_pkg::MAX_DIVISOR - 1);
          end
          state_nxt = S_HOLD;
        end else if (prod_fits) begin
          state_nxt = S_DIVIDE;
        end else if (dsel_r == srdc_pkg::DIV_W'(srdc_pkg::MAX_DIVISOR)) begin
          res_nxt.reload_value = srdc_pkg::RELOAD_W'(srdc_pkg::RELOAD_LIMIT - 1);
          res_nxt.prescale     = srdc_pkg::PRESC_W'(srdc_pkg::MAX_DIVISOR - 1);
          state_nxt            = S_HOLD;
        end else begin
          dsel_nxt = dsel_r + 1'b1;
          prod_nxt = prod_r + srdc_pkg::PROD_W'(freq_r);
        end
      end
      S_DIVIDE: begin
        if (div_st.done) begin
          res_nxt.reload_value = srdc_pkg::RELOAD_W'(div_st.quot - 1'b1);
          res_nxt.prescale     = srdc_pkg::PRESC_W'(dsel_r - 1'b1);
          state_nxt            = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk) begin
    freq_r <= freq_nxt;
    prod_r <= prod_nxt;
    dsel_r <= dsel_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  // output channel
  assign out_chan.valid        = out_valid_r;
  assign out_chan.out_axis     = out_r.axis;
  assign out_chan.reload_value = out_r.reload_value;
  assign out_chan.prescale     = out_r.prescale;
  assign out_chan.pwm_off      = out_r.pwm_off;
  assign out_chan.move_start   = out_r.move_start;
  assign out_chan.direction    = out_r.direction;
  assign out_chan.step_count   = out_r.step_count;
  assign out_chan.out_current  = out_r.drv_current;
  assign out_chan.rate_error   = out_r.rate_error;

  // an accepted command keeps the input closed until its result is stored
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_chan.ready)
    else $error("input stayed open after a command was accepted");

  // a finished division moves the sequencer to the result stage
  a_div_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVIDE) && div_st.done |=> (state_r == S_HOLD))
    else $error("division result not taken");

  // divisor under search stays within its range
  a_dsel_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |->
      (dsel_r >= srdc_pkg::DIV_W'(srdc_pkg::FIRST_DIVISOR)) &&
      (dsel_r <= srdc_pkg::DIV_W'(srdc_pkg::MAX_DIVISOR)))
    else $error("divisor out of range");

  // flags of a delivered result are consistent
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.pwm_off && out_r.rate_error) &&
                    (out_r.move_start || (out_r.step_count == '0)))
    else $error("inconsistent result flags");

endmodule

FILE: tb/srdc_rate_checker.sv
// checker that predicts and compares stepper rate divider result transactions
module srdc_rate_checker (
  input  logic        clk,
  input  logic        rst_n,
  srdc_cfg_if         cfg_mon,
  srdc_in_if          cmd_mon,
  srdc_out_if         res_mon,
  output int unsigned results_pending,
  output int unsigned mismatch_count
);

  // timer and motor figures the predictor works from
  localparam longint unsigned CLK_HZ     = 64'd84_000_000;
  localparam longint unsigned RELOAD_CAP = 64'd65535;
  localparam longint unsigned STEPS_REV  = 64'd200;
  localparam longint unsigned DIV_LAST   = 64'd256;
  localparam longint unsigned COUNT_CAP  = 64'h7FFF_FFFF;

  // own copy of the microstep index registers, zero from the start of simulation
  logic [3:0] x_ustep_idx = 4'd0;
  logic [3:0] y_ustep_idx = 4'd0;

  srdc_pkg::result_t timer_setting_q[$];
  int unsigned       fail_total = 0;
  int unsigned       open_cnt   = 0;

  assign results_pending = open_cnt;
  assign mismatch_count  = fail_total;

  // microsteps per full step, indexes past the table stick at 256
  function automatic longint unsigned ustep_factor(input logic [3:0] idx);
    longint unsigned f;
    unique case (idx)
      4'd0, 4'd1: f = 64'd1;
      4'd2, 4'd3: f = 64'd2;
      4'd4:       f = 64'd4;
      4'd5:       f = 64'd8;
      4'd6:       f = 64'd16;
      4'd7:       f = 64'd32;
      4'd8:       f = 64'd64;
      4'd9:       f = 64'd128;
      default:    f = 64'd256;
    endcase
    return f;
  endfunction

  // first divisor from 2 up whose reload fits under the cap
  function automatic void pick_divider(input longint unsigned step_hz,
                                       output logic [15:0] reload,
                                       output logic [7:0] presc);
    longint unsigned q;
    if (CLK_HZ / 2 / step_hz == 0) begin
      reload = 16'd0;
      presc  = 8'd1;
      return;
    end
    for (longint unsigned d = 2; d <= DIV_LAST; d++) begin
      q = (CLK_HZ / d) / step_hz;
      if (q >= 1 && q - 1 < RELOAD_CAP) begin
        reload = 16'(q - 1);
        presc  = 8'(d - 1);
        return;
      end
    end
    reload = 16'(RELOAD_CAP - 1);
    presc  = 8'(DIV_LAST - 1);
  endfunction

  // expected result of one command transaction
  function automatic srdc_pkg::result_t calc_timer_setting(input logic req, input logic ax,
                                                           input logic [7:0] spd,
                                                           input logic [23:0] len,
                                                           input logic [7:0] cur,
                                                           input logic [3:0] idx);
    srdc_pkg::result_t r;
    longint unsigned   scale;
    longint unsigned   mag;
    longint unsigned   steps;
    logic [15:0]       rl;
    logic [7:0]        ps;
    r = '0;
    r.axis = ax;
    scale = STEPS_REV * ustep_factor(idx);
    if (req == srdc_pkg::REQ_SET_SPEED) begin
      if (spd == 8'd0) begin
        r.pwm_off = 1'b1;
      end else begin
        pick_divider(64'(spd) * scale, rl, ps);
        r.reload_value = rl;
        r.prescale     = ps;
      end
    end else begin
      r.drv_current = cur;
      if (spd == 8'd0) begin
        r.rate_error = 1'b1;
      end else begin
        // magnitude of the q8 length, then truncate the fraction away
        mag   = len[23] ? (64'h100_0000 - 64'(len)) : 64'(len);
        steps = (mag * scale) >> 8;
        if (steps > COUNT_CAP) steps = COUNT_CAP;
        pick_divider(64'(spd) * scale, rl, ps);
        r.reload_value = rl;
        r.prescale     = ps;
        if (steps != 0) begin
          r.move_start = 1'b1;
          r.direction  = len[23];
          r.step_count = 31'(steps);
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_total++;
    end
  endtask

  // track register writes, predict on command transactions, compare on results
  always @(posedge clk) begin
    srdc_pkg::result_t want;
    logic [3:0]        idx;
    if (rst_n) begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.reg_index == srdc_pkg::REG_X_USTEP) begin
          x_ustep_idx = cfg_mon.wdata;
        end else if (cfg_mon.reg_index == srdc_pkg::REG_Y_USTEP) begin
          y_ustep_idx = cfg_mon.wdata;
        end
      end

      // results first so a command in the same cycle cannot satisfy a result
      if (res_mon.valid && res_mon.ready) begin
        if (timer_setting_q.size() == 0) begin
          $error("result transaction with no command outstanding");
          fail_total++;
        end else begin
          want = timer_setting_q.pop_front();
          check_field("out_axis", want.axis, res_mon.out_axis);
          check_field("reload_value", want.reload_value, res_mon.reload_value);
          check_field("prescale", want.prescale, res_mon.prescale);
          check_field("pwm_off", want.pwm_off, res_mon.pwm_off);
          check_field("move_start", want.move_start, res_mon.move_start);
          check_field("direction", want.direction, res_mon.direction);
          check_field("step_count", want.step_count, res_mon.step_count);
          check_field("out_current", want.drv_current, res_mon.out_current);
          check_field("rate_error", want.rate_error, res_mon.rate_error);
        end
      end

      if (cmd_mon.valid && cmd_mon.ready) begin
        idx = cmd_mon.axis ? y_ustep_idx : x_ustep_idx;
        timer_setting_q.push_back(calc_timer_setting(cmd_mon.req_type, cmd_mon.axis,
                                                     cmd_mon.speed, cmd_mon.length_q8,
                                                     cmd_mon.drive_current, idx));
      end
      open_cnt = timer_setting_q.size();
    end
  end

endmodule

FILE: tb/stepper_rate_divider_calc_top_test.sv
// testbench top: stimulus, receiver stalls and verdict for the stepper rate divider
module stepper_rate_divider_calc_top_test;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned ITEMS_PER_PH = 100;
  localparam int unsigned NUM_PHASES   = 7;
  localparam int unsigned DRAIN_CYCLES = 300;

  // indexes past the two mapped registers, written to check they are ignored
  localparam logic [srdc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [srdc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {DRAIN_ALL, DRAIN_HALF, DRAIN_RARE} drain_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned results_pending;
  int unsigned mismatch_count;
  drain_mode_t drain_mode = DRAIN_ALL;
  int unsigned drain_left = 0;

  srdc_cfg_if cfg_ch ();
  srdc_in_if  cmd_ch ();
  srdc_out_if res_ch ();

  stepper_rate_divider_calc_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_ch),
    .in_chan  (cmd_ch),
    .out_chan (res_ch)
  );

  srdc_rate_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_mon         (cfg_ch),
    .cmd_mon         (cmd_ch),
    .res_mon         (res_ch),
    .results_pending (results_pending),
    .mismatch_count  (mismatch_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stalls in stretches of changing character
  always @(posedge clk) begin
    if (drain_left == 0) begin
      drain_mode <= drain_mode_t'($urandom_range(0, 2));
      drain_left <= $urandom_range(16, 160);
    end else begin
      drain_left <= drain_left - 1;
    end
    unique case (drain_mode)
      DRAIN_ALL:  res_ch.ready <= 1'b1;
      DRAIN_HALF: res_ch.ready <= 1'($urandom_range(0, 1));
      default:    res_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // one command transaction, sent in bursts with random gaps between them
  task automatic send_command(input logic req, input logic ax, input logic [7:0] spd,
                              input logic [23:0] len, input logic [7:0] cur);
    int unsigned gap;
    if (burst_left == 0) begin
      cmd_ch.valid <= 1'b0;
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.req_type      <= req;
    cmd_ch.axis          <= ax;
    cmd_ch.speed         <= spd;
    cmd_ch.length_q8     <= len;
    cmd_ch.drive_current <= cur;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  // one register write; valid stays up for a following write
  task automatic cfg_write(input logic [srdc_pkg::CFG_IDX_W-1:0] idx, input logic [3:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // let every outstanding result arrive
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // new microstep setting once the block has gone idle
  task automatic start_phase(input logic [3:0] xi, input logic [3:0] yi, input bit spare);
    wait_idle();
    cfg_write(srdc_pkg::REG_X_USTEP, xi);
    cfg_write(srdc_pkg::REG_Y_USTEP, yi);
    if (spare) begin
      cfg_write(REG_SPARE_A, 4'hF);
      cfg_write(REG_SPARE_B, 4'h5);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic        req;
    logic        ax;
    logic [7:0]  spd;
    logic [7:0]  cur;
    logic [23:0] len;
    logic [3:0]  xi;
    logic [3:0]  yi;
    int unsigned short_len;
    int unsigned sel;

    rst_n                = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.reg_index     = srdc_pkg::REG_X_USTEP;
    cfg_ch.wdata         = 4'd0;
    cmd_ch.valid         = 1'b0;
    cmd_ch.req_type      = srdc_pkg::REQ_SET_SPEED;
    cmd_ch.axis          = 1'b0;
    cmd_ch.speed         = 8'd0;
    cmd_ch.length_q8     = 24'sd0;
    cmd_ch.drive_current = 8'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset microstep setting
    send_command(srdc_pkg::REQ_SET_SPEED, 1'b0, 8'd0, 24'h000000, 8'h00);
    send_command(srdc_pkg::REQ_SET_SPEED, 1'b0, 8'd255, 24'h000000, 8'h00);
    send_command(srdc_pkg::REQ_SET_SPEED, 1'b1, 8'd1, 24'h000000, 8'h00);
    send_command(srdc_pkg::REQ_RUN, 1'b1, 8'd0, 24'h7FFFFF, 8'hFF);
    send_command(srdc_pkg::REQ_RUN, 1'b0, 8'd1, 24'h000000, 8'h00);
    send_command(srdc_pkg::REQ_RUN, 1'b0, 8'd255, 24'h7FFFFF, 8'h55);
    send_command(srdc_pkg::REQ_RUN, 1'b1, 8'd128, 24'h800000, 8'hAA);
    // one q8 lsb backward truncates to no steps
    send_command(srdc_pkg::REQ_RUN, 1'b0, 8'd10, 24'hFFFFFF, 8'h12);
    send_command(srdc_pkg::REQ_RUN, 1'b1, 8'd10, 24'h000002, 8'h34);
    send_command(srdc_pkg::REQ_RUN, 1'b0, 8'd77, 24'hFFFFFE, 8'h56);

    // directed: indexes past the table, highest step rates and counts
    start_phase(4'd15, 4'd10, 1'b1);
    send_command(srdc_pkg::REQ_SET_SPEED, 1'b0, 8'd255, 24'h000000, 8'h00);
    send_command(srdc_pkg::REQ_SET_SPEED, 1'b1, 8'd1, 24'h000000, 8'h00);
    send_command(srdc_pkg::REQ_RUN, 1'b0, 8'd255, 24'h800000, 8'hFF);
    send_command(srdc_pkg::REQ_RUN, 1'b1, 8'd255, 24'h7FFFFF, 8'h01);
    send_command(srdc_pkg::REQ_RUN, 1'b0, 8'd0, 24'h000000, 8'h80);
    send_command(srdc_pkg::REQ_SET_SPEED, 1'b1, 8'd0, 24'h000000, 8'h00);
    send_command(srdc_pkg::REQ_RUN, 1'b1, 8'd3, 24'h000001, 8'h0F);

    start_phase(4'd9, 4'd4, 1'b0);
    send_command(srdc_pkg::REQ_RUN, 1'b0, 8'd200, 24'h123456, 8'h3C);
    send_command(srdc_pkg::REQ_SET_SPEED, 1'b1, 8'd99, 24'h000000, 8'h00);

    // random commands over several microstep settings
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      unique case (ph)
        0:       begin xi = 4'd10; yi = 4'd0;  end
        1:       begin xi = 4'd0;  yi = 4'd10; end
        2:       begin xi = 4'd15; yi = 4'd15; end
        default: begin xi = 4'($urandom_range(0, 15)); yi = 4'($urandom_range(0, 15)); end
      endcase
      start_phase(xi, yi, ph == 3);
      for (int unsigned n = 0; n < ITEMS_PER_PH; n++) begin
        req = 1'($urandom_range(0, 1));
        ax  = 1'($urandom_range(0, 1));
        cur = 8'($urandom());

        sel = $urandom_range(0, 9);
        if (sel == 0) spd = 8'd0;
        else if (sel == 1) spd = $urandom_range(0, 1) ? 8'd255 : 8'd1;
        else spd = 8'($urandom_range(1, 255));

        // lengths: extremes, short moves near zero, anything
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          len = $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
        end else if (sel <= 3) begin
          short_len = $urandom_range(0, 511);
          len = $urandom_range(0, 1) ? 24'(short_len) : -24'(short_len);
        end else begin
          len = 24'($urandom());
        end
        send_command(req, ax, spd, len, cur);
      end
    end

    // let the last results drain, then watch for strays
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: stepper_rate_divider_calc_top.f
design/srdc_pkg.sv
design/srdc_cfg_if.sv
design/srdc_in_if.sv
design/srdc_out_if.sv
design/srdc_div.sv
design/stepper_rate_divider_calc_top.sv
tb/srdc_rate_checker.sv
tb/stepper_rate_divider_calc_top_test.sv
